[rtl/core/y2p_pkg.sv]
// Shared types, constants and helpers of the YUYV to planar 4:2:0 converter.
package y2p_pkg;

  localparam int unsigned MaxWidth   = 4096;
  localparam int unsigned MaxHeight  = 4096;
  localparam int unsigned StoreDepth = MaxWidth / 2;
  localparam int unsigned ColW       = $clog2(StoreDepth);
  localparam int unsigned RowW       = $clog2(MaxHeight);
  localparam int unsigned CfgW       = 13;
  localparam int unsigned HalfW      = ColW + 1;
  localparam int unsigned LumaOffW   = 24;
  localparam int unsigned ChromaOffW = 22;

  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  // Effective frame geometry, kept in the form the datapath uses.
  typedef struct packed {
    logic [HalfW-1:0] w_half;    // macropixels per line
    logic [RowW-1:0]  last_row;  // index of the last line
  } cfg_t;

  // One classified macropixel passed from the front to the back.
  typedef struct packed {
    logic [7:0]      y0;
    logic [7:0]      u;
    logic [7:0]      y1;
    logic [7:0]      v;
    logic [ColW-1:0] col;
    logic [RowW-1:0] row;
    logic            fend;
  } cmd_t;

  // One finished result item.
  typedef struct packed {
    logic [LumaOffW-1:0]   luma_offset;
    logic [7:0]            luma_left;
    logic [7:0]            luma_right;
    logic                  chroma_valid;
    logic [ChromaOffW-1:0] chroma_offset;
    logic [7:0]            blue_avg;
    logic [7:0]            red_avg;
    logic                  frame_end;
  } res_t;

  // Width clamped to 2..MaxWidth and rounded down to even, halved.
  function automatic logic [HalfW-1:0] width_half(input logic [CfgW-1:0] raw);
    logic [HalfW-1:0] res;
    if (raw < CfgW'(2)) begin
      res = HalfW'(1);
    end else if (raw > CfgW'(MaxWidth)) begin
      res = HalfW'(MaxWidth / 2);
    end else begin
      res = HalfW'(raw >> 1);
    end
    return res;
  endfunction

  // Height clamped to 2..MaxHeight, minus one.
  function automatic logic [RowW-1:0] height_last(input logic [CfgW-1:0] raw);
    logic [RowW-1:0] res;
    if (raw < CfgW'(2)) begin
      res = RowW'(1);
    end else if (raw > CfgW'(MaxHeight)) begin
      res = RowW'(MaxHeight - 1);
    end else begin
      res = RowW'(raw - CfgW'(1));
    end
    return res;
  endfunction

endpackage

[rtl/core/yuyv_to_planar_420.sv]
// Top level of the YUYV to planar 4:2:0 converter.
// Usage: YUYV macropixels enter in raster order through a queue-style port:
// an item is taken at a clock edge where push_i is high and full_o is low.
// Each item yields one result, read from a queue-style port: while empty_o
// is low the oldest result is on the outputs and pop_i takes it.
// Every result carries both luma samples and their luma-plane offset; on odd
// lines it also carries the 2x2 averaged U and V with their chroma offset.
// An accepted item passes the item queue and the pipeline register into the
// result queue; one item per cycle is sustained while results are popped.
// The single-port chroma line store is written on even lines, read on odd.
// A stalled receiver fills the four-entry result queue and then the
// two-entry item queue, after which full_o rises; nothing is lost.
// Frame size is written through cfg_we_i, cfg_idx_i and cfg_data_i while
// the block is idle. Reset sets 640 by 480, clears the queues and puts the
// raster position at the first macropixel. The line store needs no clearing
// because every odd line reads entries written by the line above it.
module yuyv_to_planar_420 import y2p_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic                  cfg_idx_i,
  input  logic [CfgW-1:0]       cfg_data_i,
  input  logic                  push_i,
  output logic                  full_o,
  input  logic [7:0]            luma_first_i,
  input  logic [7:0]            chroma_blue_i,
  input  logic [7:0]            luma_second_i,
  input  logic [7:0]            chroma_red_i,
  output logic                  empty_o,
  input  logic                  pop_i,
  output logic [LumaOffW-1:0]   luma_offset_o,
  output logic [7:0]            luma_left_o,
  output logic [7:0]            luma_right_o,
  output logic                  chroma_valid_o,
  output logic [ChromaOffW-1:0] chroma_offset_o,
  output logic [7:0]            blue_avg_o,
  output logic [7:0]            red_avg_o,
  output logic                  frame_end_o
);

  cfg_t cfg;
  cmd_t cmd_in;
  cmd_t cmd_out;
  logic accept;
  logic cmd_empty;
  logic cmd_pop;
  res_t res;

  assign accept = push_i && !full_o;

  y2p_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .accept_i      (accept),
    .luma_first_i  (luma_first_i),
    .chroma_blue_i (chroma_blue_i),
    .luma_second_i (luma_second_i),
    .chroma_red_i  (chroma_red_i),
    .cfg_o         (cfg),
    .cmd_o         (cmd_in)
  );

  y2p_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .data_i  (cmd_in),
    .full_o  (full_o),
    .pop_i   (cmd_pop),
    .empty_o (cmd_empty),
    .data_o  (cmd_out)
  );

  y2p_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (cmd_out),
    .cmd_pop_o   (cmd_pop),
    .pop_i       (pop_i),
    .empty_o     (empty_o),
    .res_o       (res)
  );

  assign luma_offset_o   = res.luma_offset;
  assign luma_left_o     = res.luma_left;
  assign luma_right_o    = res.luma_right;
  assign chroma_valid_o  = res.chroma_valid;
  assign chroma_offset_o = res.chroma_offset;
  assign blue_avg_o      = res.blue_avg;
  assign red_avg_o       = res.red_avg;
  assign frame_end_o     = res.frame_end;

endmodule

[rtl/core/y2p_front.sv]
// Front part: configuration registers, item intake and raster position counters.
module y2p_front import y2p_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic            cfg_idx_i,
  input  logic [CfgW-1:0] cfg_data_i,
  input  logic            accept_i,
  input  logic [7:0]      luma_first_i,
  input  logic [7:0]      chroma_blue_i,
  input  logic [7:0]      luma_second_i,
  input  logic [7:0]      chroma_red_i,
  output cfg_t            cfg_o,
  output cmd_t            cmd_o
);

  cfg_t            cfg_q, cfg_d;
  logic [ColW-1:0] col_q, col_d;
  logic [RowW-1:0] row_q, row_d;
  logic [ColW-1:0] last_col;
  logic            line_end;
  logic            fend;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_FRAME_WIDTH:  cfg_d.w_half   = width_half(cfg_data_i);
        REG_FRAME_HEIGHT: cfg_d.last_row = height_last(cfg_data_i);
        default: cfg_d = cfg_q;
      endcase
    end
  end

  assign last_col = ColW'(cfg_q.w_half - HalfW'(1));
  // A counter at or past its last value wraps, so a mid-frame change of size is safe.
  assign line_end = (col_q >= last_col);
  assign fend     = line_end && (row_q >= cfg_q.last_row);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept_i) begin
      if (line_end) begin
        col_d = '0;
        row_d = fend ? '0 : row_q + RowW'(1);
      end else begin
        col_d = col_q + ColW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.w_half   <= HalfW'(320);
      cfg_q.last_row <= RowW'(479);
      col_q          <= '0;
      row_q          <= '0;
    end else begin
      cfg_q <= cfg_d;
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  assign cfg_o      = cfg_q;
  assign cmd_o.y0   = luma_first_i;
  assign cmd_o.u    = chroma_blue_i;
  assign cmd_o.y1   = luma_second_i;
  assign cmd_o.v    = chroma_red_i;
  assign cmd_o.col  = col_q;
  assign cmd_o.row  = row_q;
  assign cmd_o.fend = fend;

endmodule

[rtl/core/y2p_queue.sv]
// Two-entry queue of classified items between the front and the back part.
module y2p_queue import y2p_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t data_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output cmd_t data_o
);

  cmd_t       mem_q [2];
  logic       wr_q, wr_d;
  logic       rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = do_push ? ~wr_q : wr_q;
    rd_d  = do_pop ? ~rd_q : rd_q;
    cnt_d = cnt_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

[rtl/core/y2p_back.sv]
// Back part: chroma line store, offset arithmetic, averaging and the result queue.
module y2p_back import y2p_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  logic cmd_empty_i,
  input  cmd_t cmd_i,
  output logic cmd_pop_o,
  input  logic pop_i,
  output logic empty_o,
  output res_t res_o
);

  localparam int unsigned OutDepth = 4;
  localparam int unsigned OutPtrW  = $clog2(OutDepth);
  localparam int unsigned OutCntW  = OutPtrW + 1;
  localparam int unsigned ProdLW   = RowW + HalfW + 1;
  localparam int unsigned ProdCW   = RowW - 1 + HalfW;

  logic [15:0]        store_q [StoreDepth];
  logic [15:0]        rd_data_q;
  logic               v1_q;
  cmd_t               cmd1_q;
  logic [ProdLW-1:0]  prod_l_q;
  logic [ProdCW-1:0]  prod_c_q;
  res_t               fifo_q [OutDepth];
  logic [OutPtrW-1:0] wr_q, wr_d;
  logic [OutPtrW-1:0] rd_q, rd_d;
  logic [OutCntW-1:0] cnt_q, cnt_d;
  logic               issue;
  logic               do_pop;
  logic [HalfW:0]     width_full;
  logic [ProdLW-1:0]  luma_sum;
  logic [ProdCW-1:0]  chroma_sum;
  logic [8:0]         blue_sum;
  logic [8:0]         red_sum;
  res_t               res_new;

  // An item enters the pipeline only when the result queue has room for it.
  assign issue     = !cmd_empty_i && ((cnt_q + OutCntW'(v1_q)) < OutCntW'(OutDepth));
  assign cmd_pop_o = issue;
  assign width_full = {cfg_i.w_half, 1'b0};

  always_ff @(posedge clk_i) begin
    if (issue && !cmd_i.row[0]) begin
      store_q[cmd_i.col] <= {cmd_i.v, cmd_i.u};
    end
    if (issue && cmd_i.row[0]) begin
      rd_data_q <= store_q[cmd_i.col];
    end
    if (issue) begin
      cmd1_q   <= cmd_i;
      prod_l_q <= ProdLW'(cmd_i.row) * ProdLW'(width_full);
      prod_c_q <= ProdCW'(cmd_i.row[RowW-1:1]) * ProdCW'(cfg_i.w_half);
    end
  end

  always_comb begin
    luma_sum   = prod_l_q + ProdLW'({cmd1_q.col, 1'b0});
    chroma_sum = prod_c_q + ProdCW'(cmd1_q.col);
    blue_sum   = {1'b0, rd_data_q[7:0]} + {1'b0, cmd1_q.u};
    red_sum    = {1'b0, rd_data_q[15:8]} + {1'b0, cmd1_q.v};
    res_new.luma_offset  = luma_sum[LumaOffW-1:0];
    res_new.luma_left    = cmd1_q.y0;
    res_new.luma_right   = cmd1_q.y1;
    res_new.chroma_valid = cmd1_q.row[0];
    res_new.frame_end    = cmd1_q.fend;
    if (cmd1_q.row[0]) begin
      res_new.chroma_offset = chroma_sum[ChromaOffW-1:0];
      res_new.blue_avg      = blue_sum[8:1];
      res_new.red_avg       = red_sum[8:1];
    end else begin
      res_new.chroma_offset = '0;
      res_new.blue_avg      = '0;
      res_new.red_avg       = '0;
    end
  end

  assign empty_o = (cnt_q == '0);
  assign do_pop  = pop_i && !empty_o;
  assign res_o   = fifo_q[rd_q];

  always_comb begin
    wr_d  = v1_q ? wr_q + OutPtrW'(1) : wr_q;
    rd_d  = do_pop ? rd_q + OutPtrW'(1) : rd_q;
    cnt_d = cnt_q + OutCntW'(v1_q) - OutCntW'(do_pop);
  end

  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      fifo_q[wr_q] <= res_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      v1_q  <= issue;
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

`ifndef SYNTHESIS
  a_credit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q + OutCntW'(v1_q)) <= OutCntW'(OutDepth))
    else $error("result queue overcommitted");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q |-> (cnt_q < OutCntW'(OutDepth)) || do_pop)
    else $error("result written into a full queue");

  a_even_no_chroma: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && !res_new.chroma_valid) |->
      (res_new.blue_avg == '0) && (res_new.red_avg == '0) && (res_new.chroma_offset == '0))
    else $error("chroma fields set on an even row");

  a_issue_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (issue && !v1_q && !do_pop) |=> (cnt_q == $past(cnt_q)))
    else $error("result count moved without a push or pop");
`endif

endmodule
